// ----- hw/rtl/pff_pkg.sv -----
// Shared types, widths and codes of the Pareto frontier filter.
// Used by pff_mem, pff_seq, pff_out and pareto_frontier_filter_top.
`default_nettype none

package pff_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int REC_W    = 17;
    localparam int THR_W    = 32;
    localparam int TAG_W    = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_e;

    typedef enum logic [KIND_W-1:0] {
        KIND_STATUS = 2'd0,
        KIND_ENTRY  = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_DOMINATED = 2'd1,
        ST_FULL      = 2'd2
    } status_e;

    typedef struct packed {
        logic [REC_W-1:0] recall;
        logic [THR_W-1:0] throughput;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        kind_e              kind;
        status_e            status;
        entry_t             entry;
        logic [COUNT_W-1:0] count;
        logic               last;
    } result_t;

    function automatic result_t make_res(kind_e k, status_e s, entry_t e, logic l);
        result_t r;
        r.kind   = k;
        r.status = s;
        r.entry  = e;
        r.count  = '0;
        r.last   = l;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pff_mem.sv -----
// Frontier point store: one write port, one read port, registered read data.
// Depends on pff_pkg for the entry type.
`default_nettype none

module pff_mem #(
    parameter int DEPTH = pff_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output pff_pkg::entry_t      rd_data,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire pff_pkg::entry_t wr_data
);

    pff_pkg::entry_t mem [DEPTH];
    pff_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/pff_out.sv -----
// Result register between the sequencer and the output channel.
// Depends on pff_pkg for the result type.
`default_nettype none

module pff_out (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire pff_pkg::result_t              res,
    output logic                               free,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [pff_pkg::KIND_W-1:0]         kind,
    output logic [pff_pkg::STATUS_W-1:0]       status,
    output logic [pff_pkg::REC_W-1:0]          entry_recall,
    output logic [pff_pkg::THR_W-1:0]          entry_throughput,
    output logic [pff_pkg::TAG_W-1:0]          entry_tag,
    output logic [pff_pkg::COUNT_W-1:0]        frontier_count,
    output logic                               last
);

    logic              valid_reg;
    logic              valid_next;
    pff_pkg::result_t  res_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid        = valid_reg;
    assign kind             = res_reg.kind;
    assign status           = res_reg.status;
    assign entry_recall     = res_reg.entry.recall;
    assign entry_throughput = res_reg.entry.throughput;
    assign entry_tag        = res_reg.entry.tag;
    assign frontier_count   = res_reg.count;
    assign last             = res_reg.last;

endmodule

`default_nettype wire

// ----- hw/rtl/pff_seq.sv -----
// Sequencer: insert walk with move-last removal, selection-sort readout, clear.
// Depends on pff_pkg; drives the ports of pff_mem and loads pff_out.
`default_nettype none

module pff_seq #(
    parameter int CAPACITY = pff_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [pff_pkg::CMD_W-1:0]  command,
    input  wire logic [pff_pkg::REC_W-1:0]  recall_value,
    input  wire logic [pff_pkg::THR_W-1:0]  throughput,
    input  wire logic [pff_pkg::TAG_W-1:0]  point_tag,
    output logic                            rd_en,
    output logic [AW-1:0]                   rd_addr,
    input  wire pff_pkg::entry_t            rd_data,
    output logic                            wr_en,
    output logic [AW-1:0]                   wr_addr,
    output pff_pkg::entry_t                 wr_data,
    input  wire logic                       out_free,
    output logic                            out_load,
    output pff_pkg::result_t                out_res
);

    localparam int OW = $clog2(CAPACITY + 1);
    localparam int KW = pff_pkg::THR_W + pff_pkg::TAG_W + pff_pkg::REC_W + AW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_FIN  = 5'b00100,
        S_SORT = 5'b01000,
        S_RESP = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [OW-1:0]     occ_reg, occ_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              moving_reg, moving_next;
    logic [OW-1:0]     iss_reg, iss_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic              best_vld_reg, best_vld_next;
    logic              first_reg, first_next;
    logic [OW-1:0]     sent_reg, sent_next;
    logic              more_reg, more_next;

    logic [AW-1:0]     cmp_slot_reg, cmp_slot_next;
    pff_pkg::entry_t   new_reg, new_next;
    logic [KW-1:0]     best_key_reg, best_key_next;
    logic [KW-1:0]     prev_key_reg, prev_key_next;
    pff_pkg::result_t  res_reg, res_next;

    logic              accept;
    logic [OW-1:0]     occ_dec;
    logic [OW-1:0]     idx_ext;
    logic [OW-1:0]     idx_inc;
    logic [OW-1:0]     sent_inc;
    logic              le_new;
    logic              ge_new;
    logic [KW-1:0]     key_cur;
    logic              cand;
    logic [KW-1:0]     win_key;
    pff_pkg::entry_t   win_entry;
    pff_pkg::entry_t   in_entry;

    assign accept   = in_valid && in_ready;
    assign occ_dec  = occ_reg - 1'b1;
    assign idx_ext  = OW'(idx_reg);
    assign idx_inc  = idx_ext + 1'b1;
    assign sent_inc = sent_reg + 1'b1;

    assign le_new = (rd_data.recall <= new_reg.recall)
                 && (rd_data.throughput <= new_reg.throughput);
    assign ge_new = (new_reg.recall <= rd_data.recall)
                 && (new_reg.throughput <= rd_data.throughput);

    assign key_cur = {~rd_data.throughput, rd_data.tag, rd_data.recall, cmp_slot_reg};
    assign cand    = (first_reg || (key_cur > prev_key_reg))
                  && (!best_vld_reg || (key_cur < best_key_reg));
    assign win_key = cand ? key_cur : best_key_reg;

    assign win_entry.recall     = win_key[AW +: pff_pkg::REC_W];
    assign win_entry.tag        = win_key[AW + pff_pkg::REC_W +: pff_pkg::TAG_W];
    assign win_entry.throughput =
        ~win_key[AW + pff_pkg::REC_W + pff_pkg::TAG_W +: pff_pkg::THR_W];

    assign in_entry.recall     = recall_value;
    assign in_entry.throughput = throughput;
    assign in_entry.tag        = point_tag;

    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        idx_next      = idx_reg;
        moving_next   = moving_reg;
        iss_next      = iss_reg;
        cmp_vld_next  = 1'b0;
        best_vld_next = best_vld_reg;
        first_next    = first_reg;
        sent_next     = sent_reg;
        more_next     = more_reg;
        cmp_slot_next = cmp_slot_reg;
        new_next      = new_reg;
        best_key_next = best_key_reg;
        prev_key_next = prev_key_reg;
        res_next      = res_reg;

        in_ready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_data  = rd_data;
        out_load = 1'b0;
        out_res  = res_reg;
        out_res.count = pff_pkg::COUNT_W'(occ_reg);

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    new_next  = in_entry;
                    more_next = 1'b0;
                    case (pff_pkg::cmd_e'(command))
                        pff_pkg::CMD_INSERT:
                        begin
                            idx_next    = '0;
                            moving_next = 1'b0;
                            if (occ_reg == '0)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_WALK;
                            end
                        end
                        pff_pkg::CMD_READ:
                        begin
                            if (occ_reg == '0)
                            begin
                                res_next = pff_pkg::make_res(pff_pkg::KIND_ENTRY,
                                    pff_pkg::ST_INSERTED, '0, 1'b1);
                                state_next = S_RESP;
                            end
                            else
                            begin
                                iss_next      = '0;
                                best_vld_next = 1'b0;
                                first_next    = 1'b1;
                                sent_next     = '0;
                                state_next    = S_SORT;
                            end
                        end
                        pff_pkg::CMD_CLEAR:
                        begin
                            occ_next = '0;
                            res_next = pff_pkg::make_res(pff_pkg::KIND_CLEAR,
                                pff_pkg::ST_INSERTED, '0, 1'b1);
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // write back the entry moved down from the end of the store
                wr_en       = moving_reg;
                wr_addr     = idx_reg;
                wr_data     = rd_data;
                moving_next = 1'b0;
                if (le_new)
                begin
                    occ_next = occ_dec;
                    if (idx_ext < occ_dec)
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = AW'(occ_dec);
                        moving_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else if (ge_new)
                begin
                    res_next = pff_pkg::make_res(pff_pkg::KIND_STATUS,
                        pff_pkg::ST_DOMINATED, '0, 1'b1);
                    state_next = S_RESP;
                end
                else if (idx_inc < occ_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(idx_inc);
                    idx_next = AW'(idx_inc);
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (occ_reg >= OW'(CAPACITY))
                begin
                    res_next = pff_pkg::make_res(pff_pkg::KIND_STATUS,
                        pff_pkg::ST_FULL, '0, 1'b1);
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = AW'(occ_reg);
                    wr_data  = new_reg;
                    occ_next = occ_reg + 1'b1;
                    res_next = pff_pkg::make_res(pff_pkg::KIND_STATUS,
                        pff_pkg::ST_INSERTED, '0, 1'b1);
                end
                state_next = S_RESP;
            end

            S_SORT:
            begin
                if (iss_reg < occ_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = AW'(iss_reg);
                    iss_next      = iss_reg + 1'b1;
                    cmp_vld_next  = 1'b1;
                    cmp_slot_next = AW'(iss_reg);
                end
                if (cmp_vld_reg)
                begin
                    if (cand)
                    begin
                        best_key_next = key_cur;
                        best_vld_next = 1'b1;
                    end
                    if (cmp_slot_reg == AW'(occ_dec))
                    begin
                        res_next = pff_pkg::make_res(pff_pkg::KIND_ENTRY,
                            pff_pkg::ST_INSERTED, win_entry, sent_inc == occ_reg);
                        more_next     = (sent_inc != occ_reg);
                        prev_key_next = win_key;
                        first_next    = 1'b0;
                        sent_next     = sent_inc;
                        state_next    = S_RESP;
                    end
                end
            end

            S_RESP:
            begin
                out_load = out_free;
                if (out_free)
                begin
                    if (more_reg)
                    begin
                        iss_next      = '0;
                        best_vld_next = 1'b0;
                        state_next    = S_SORT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            idx_reg      <= '0;
            moving_reg   <= 1'b0;
            iss_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            best_vld_reg <= 1'b0;
            first_reg    <= 1'b0;
            sent_reg     <= '0;
            more_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            idx_reg      <= idx_next;
            moving_reg   <= moving_next;
            iss_reg      <= iss_next;
            cmp_vld_reg  <= cmp_vld_next;
            best_vld_reg <= best_vld_next;
            first_reg    <= first_next;
            sent_reg     <= sent_next;
            more_reg     <= more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_slot_reg <= cmp_slot_next;
        new_reg      <= new_next;
        best_key_reg <= best_key_next;
        prev_key_reg <= prev_key_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pareto_frontier_filter_top.sv -----
// Top level of the Pareto frontier filter: point store, sequencer, result register.
// Depends on pff_pkg, pff_mem, pff_seq and pff_out.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------------
//   in      | in_valid / in_ready    | command, recall_value, throughput, point_tag
//   out     | out_valid / out_ready  | kind, status, entry_recall, entry_throughput,
//           |                        | entry_tag, frontier_count, last
//
// Insert: one store read per cycle in the walk over the stored points.
// Readout: one full store scan per emitted entry.
// Clear empties the frontier; an unused command gives no transfer.
// Reset empties the frontier; the store itself is not cleared.
// One item at a time; a result waiting on out_ready stalls only the next result.
`default_nettype none

module pareto_frontier_filter_top #(
    parameter int CAPACITY = pff_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [pff_pkg::CMD_W-1:0]     command,
    input  wire logic [pff_pkg::REC_W-1:0]     recall_value,
    input  wire logic [pff_pkg::THR_W-1:0]     throughput,
    input  wire logic [pff_pkg::TAG_W-1:0]     point_tag,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [pff_pkg::KIND_W-1:0]         kind,
    output logic [pff_pkg::STATUS_W-1:0]       status,
    output logic [pff_pkg::REC_W-1:0]          entry_recall,
    output logic [pff_pkg::THR_W-1:0]          entry_throughput,
    output logic [pff_pkg::TAG_W-1:0]          entry_tag,
    output logic [pff_pkg::COUNT_W-1:0]        frontier_count,
    output logic                               last
);

    localparam int AW = $clog2(CAPACITY);

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    pff_pkg::entry_t   rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    pff_pkg::entry_t   wr_data;
    logic              out_free;
    logic              out_load;
    pff_pkg::result_t  out_res;

    pff_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    pff_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .recall_value (recall_value),
        .throughput   (throughput),
        .point_tag    (point_tag),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .out_free     (out_free),
        .out_load     (out_load),
        .out_res      (out_res)
    );

    pff_out u_out (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (out_load),
        .res              (out_res),
        .free             (out_free),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .status           (status),
        .entry_recall     (entry_recall),
        .entry_throughput (entry_throughput),
        .entry_tag        (entry_tag),
        .frontier_count   (frontier_count),
        .last             (last)
    );

endmodule

`default_nettype wire
